// ===== src/bawe_pkg.sv =====
package bawe_pkg;

    localparam int WORD_W     = 64;
    localparam int ACC_W      = 48;
    localparam int DIVISOR_W  = 16;
    localparam int DIVIDEND_W = ACC_W + 1;
    localparam int ROOT_W     = WORD_W / 2;
    localparam int STEP_W     = 5;
    localparam int OP_W       = 5;
    localparam int COND_W     = 4;

    typedef struct packed {
        logic [31:0] sample;
        logic        restart;
    } item_t;

    typedef struct packed {
        logic [15:0] blocks_seen;
        logic [31:0] throws;
        logic [31:0] running_mean;
        logic [31:0] running_error;
        logic        full_res;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    localparam logic REG_BLOCK_LENGTH = 1'b0;
    localparam logic REG_MEASURE_MODE = 1'b1;

    localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT   = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD_V   = 5'd2;
    localparam logic [OP_W-1:0] OP_ADD_V    = 5'd3;
    localparam logic [OP_W-1:0] OP_DIV_LEN  = 5'd4;
    localparam logic [OP_W-1:0] OP_MEAN     = 5'd5;
    localparam logic [OP_W-1:0] OP_ADD_SQ   = 5'd6;
    localparam logic [OP_W-1:0] OP_DIV_KM   = 5'd7;
    localparam logic [OP_W-1:0] OP_AVG      = 5'd8;
    localparam logic [OP_W-1:0] OP_DIV_KS   = 5'd9;
    localparam logic [OP_W-1:0] OP_AVGSQ    = 5'd10;
    localparam logic [OP_W-1:0] OP_VAR      = 5'd11;
    localparam logic [OP_W-1:0] OP_DIV_KM1  = 5'd12;
    localparam logic [OP_W-1:0] OP_SQRT_GO  = 5'd13;
    localparam logic [OP_W-1:0] OP_ERR      = 5'd14;
    localparam logic [OP_W-1:0] OP_EMIT     = 5'd15;
    localparam logic [OP_W-1:0] OP_SQ_LO    = 5'd16;
    localparam logic [OP_W-1:0] OP_SQ_X     = 5'd17;
    localparam logic [OP_W-1:0] OP_SQ_ADD   = 5'd18;
    localparam logic [OP_W-1:0] OP_SQ_RND   = 5'd19;

    localparam logic [COND_W-1:0] C_NEXT     = 4'd0;
    localparam logic [COND_W-1:0] C_GOTO     = 4'd1;
    localparam logic [COND_W-1:0] C_NO_REQ   = 4'd2;
    localparam logic [COND_W-1:0] C_FULL     = 4'd3;
    localparam logic [COND_W-1:0] C_MODE0    = 4'd4;
    localparam logic [COND_W-1:0] C_BUSY     = 4'd5;
    localparam logic [COND_W-1:0] C_NOT_END  = 4'd6;
    localparam logic [COND_W-1:0] C_FIRST    = 4'd7;
    localparam logic [COND_W-1:0] C_OUT_BUSY = 4'd8;
    localparam logic [COND_W-1:0] C_CALL     = 4'd9;
    localparam logic [COND_W-1:0] C_RET      = 4'd10;

    localparam logic [STEP_W-1:0] S_IDLE      = 5'd0;
    localparam logic [STEP_W-1:0] S_ADD       = 5'd4;
    localparam logic [STEP_W-1:0] S_WAIT_LEN  = 5'd7;
    localparam logic [STEP_W-1:0] S_WAIT_KM   = 5'd11;
    localparam logic [STEP_W-1:0] S_WAIT_KS   = 5'd14;
    localparam logic [STEP_W-1:0] S_WAIT_KM1  = 5'd19;
    localparam logic [STEP_W-1:0] S_WAIT_SQRT = 5'd21;
    localparam logic [STEP_W-1:0] S_WAIT_OUT  = 5'd23;
    localparam logic [STEP_W-1:0] S_SQ        = 5'd25;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        unique case (step)
            5'd0:    cw = '{OP_ACCEPT,  C_NO_REQ,   S_IDLE};
            5'd1:    cw = '{OP_NOP,     C_FULL,     S_IDLE};
            5'd2:    cw = '{OP_LOAD_V,  C_MODE0,    S_ADD};
            5'd3:    cw = '{OP_NOP,     C_CALL,     S_SQ};
            5'd4:    cw = '{OP_ADD_V,   C_NEXT,     S_IDLE};
            5'd5:    cw = '{OP_NOP,     C_NOT_END,  S_IDLE};
            5'd6:    cw = '{OP_DIV_LEN, C_NEXT,     S_IDLE};
            5'd7:    cw = '{OP_NOP,     C_BUSY,     S_WAIT_LEN};
            5'd8:    cw = '{OP_MEAN,    C_CALL,     S_SQ};
            5'd9:    cw = '{OP_ADD_SQ,  C_NEXT,     S_IDLE};
            5'd10:   cw = '{OP_DIV_KM,  C_NEXT,     S_IDLE};
            5'd11:   cw = '{OP_NOP,     C_BUSY,     S_WAIT_KM};
            5'd12:   cw = '{OP_AVG,     C_NEXT,     S_IDLE};
            5'd13:   cw = '{OP_DIV_KS,  C_NEXT,     S_IDLE};
            5'd14:   cw = '{OP_NOP,     C_BUSY,     S_WAIT_KS};
            5'd15:   cw = '{OP_AVGSQ,   C_FIRST,    S_WAIT_OUT};
            5'd16:   cw = '{OP_NOP,     C_CALL,     S_SQ};
            5'd17:   cw = '{OP_VAR,     C_NEXT,     S_IDLE};
            5'd18:   cw = '{OP_DIV_KM1, C_NEXT,     S_IDLE};
            5'd19:   cw = '{OP_NOP,     C_BUSY,     S_WAIT_KM1};
            5'd20:   cw = '{OP_SQRT_GO, C_NEXT,     S_IDLE};
            5'd21:   cw = '{OP_NOP,     C_BUSY,     S_WAIT_SQRT};
            5'd22:   cw = '{OP_ERR,     C_NEXT,     S_IDLE};
            5'd23:   cw = '{OP_NOP,     C_OUT_BUSY, S_WAIT_OUT};
            5'd24:   cw = '{OP_EMIT,    C_GOTO,     S_IDLE};
            5'd25:   cw = '{OP_SQ_LO,   C_NEXT,     S_IDLE};
            5'd26:   cw = '{OP_SQ_X,    C_NEXT,     S_IDLE};
            5'd27:   cw = '{OP_SQ_ADD,  C_NEXT,     S_IDLE};
            5'd28:   cw = '{OP_SQ_RND,  C_RET,      S_IDLE};
            default: cw = '{OP_NOP,     C_GOTO,     S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

// ===== src/bawe_div.sv =====
module bawe_div
    import bawe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ACC_W-1:0]      dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] num_reg, num_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, num_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            num_next  = {1'b0, dividend} + DIVIDEND_W'(divisor >> 1);
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? DIVISOR_W'(trial - {1'b0, den_reg}) : DIVISOR_W'(trial);
            num_next  = {num_reg[DIVIDEND_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = num_reg;

endmodule

// ===== src/bawe_isqrt.sv =====
module bawe_isqrt
    import bawe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] operand,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    logic [WORD_W-1:0] x_reg, x_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [WORD_W-1:0] bit_reg, bit_next;
    logic              busy_reg, busy_next;
    logic [WORD_W-1:0] trial;
    logic              fits;

    assign trial = res_reg + bit_reg;
    assign fits  = x_reg >= trial;

    always_comb
    begin
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (start)
        begin
            x_next    = operand;
            res_next  = '0;
            bit_next  = WORD_W'(1) << (WORD_W - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next    = fits ? x_reg - trial : x_reg;
            res_next  = fits ? (res_reg >> 1) + bit_reg : res_reg >> 1;
            bit_next  = bit_reg >> 2;
            busy_next = (bit_reg >> 2) != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            bit_reg  <= bit_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ===== src/blocking_average_with_error.sv =====
// Block-averaging mean and standard-error estimator for a stream of Q0.32 samples.
// Requests arrive on item (sample, restart) under item_valid / item_stall; results
// leave on result under result_valid / result_stall. A request is taken at a clock
// edge where valid is high and stall is low. block_length and measure_mode are
// written over the APB port at byte addresses 0 and 4; pready is always high.
// A microcoded sequencer works on one request at a time. A request that does not
// close a block runs one square subroutine in mode 1 and none in mode 0; a request
// ignored because the block counter is full is dropped and the sequencer goes idle.
// A request that closes a block then runs four 49-step restoring divisions, a
// 32-step square root and two square subroutines (for the first block: three
// divisions, one square subroutine and no square root), and waits while a result
// still held in the output register is stalled.
// Once the block counter is full, requests are taken and ignored until a restart.
// The result sits in an output register; while the receiver stalls, the next
// request is still taken and the sequencer only waits if another block closes.
// Reset clears all accumulators and sets block_length to 1000 and measure_mode
// to 0; no result is pending after reset.
module blocking_average_with_error
    import bawe_pkg::*;
#(
    parameter int FRAC_BITS  = 32,
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    localparam logic [FRAC_BITS-1:0]  HALF_F    = {1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic [WORD_W-1:0]     HALF_Q    = WORD_W'(HALF_F);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [15:0]           block_length_reg;
    logic                  measure_mode_reg;
    logic [STEP_W-1:0]     pc_reg, pc_next;
    logic [STEP_W-1:0]     ret_reg, ret_next;
    logic [15:0]           samples_reg, samples_next;
    logic [ACC_W-1:0]      total_reg, total_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [ACC_W-1:0]      sum_means_reg, sum_means_next;
    logic [ACC_W-1:0]      sum_sq_reg, sum_sq_next;
    logic                  result_valid_reg, result_valid_next;
    logic [FRAC_BITS-1:0]  s_reg, s_next;
    logic [WORD_W-1:0]     a_reg, a_next;
    logic [WORD_W-1:0]     t_reg, t_next;
    logic [WORD_W-1:0]     avg_reg, avg_next;
    logic [WORD_W-1:0]     prod_reg, prod_next;
    logic [31:0]           cross_reg, cross_next;
    logic [ROOT_W-1:0]     err_reg, err_next;
    result_t               result_reg, result_next;

    ctrl_t                 cw;
    logic                  take;
    logic                  cfg_write;
    logic [15:0]           len;
    logic [15:0]           k16;
    logic                  full;
    logic [FRAC_BITS-1:0]  dev;
    logic [WORD_W-1:0]     sq_lo;
    logic [31:0]           cross_w;
    logic [WORD_W-1:0]     rnd_sum;
    logic [31:0]           throws_w;
    logic                  div_start;
    logic [ACC_W-1:0]      div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_busy;
    logic [DIVIDEND_W-1:0] quot;
    logic [WORD_W-1:0]     quot64;
    logic                  sqrt_start;
    logic                  sqrt_busy;
    logic [ROOT_W-1:0]     root;

    assign cw         = ucode(pc_reg);
    assign item_stall = pc_reg != S_IDLE;
    assign take       = item_valid && !item_stall;
    assign cfg_write  = psel && penable && pwrite;
    assign pready     = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_BLOCK_LENGTH: prdata = {16'b0, block_length_reg};
            REG_MEASURE_MODE: prdata = {31'b0, measure_mode_reg};
            default:          prdata = '0;
        endcase
    end

    assign len      = (block_length_reg == 16'd0) ? 16'd1 : block_length_reg;
    assign k16      = 16'(count_reg);
    assign full     = count_reg == COUNT_MAX;
    assign dev      = (s_reg >= HALF_F) ? s_reg - HALF_F : HALF_F - s_reg;
    assign sq_lo    = a_reg[31:0] * a_reg[31:0];
    assign cross_w  = 32'(a_reg[63:32] * a_reg[31:0]);
    assign rnd_sum  = prod_reg + HALF_Q;
    assign throws_w = 32'(k16) * 32'(len);
    assign quot64   = WORD_W'(quot);

    assign div_start  = (cw.op == OP_DIV_LEN) || (cw.op == OP_DIV_KM) ||
                        (cw.op == OP_DIV_KS) || (cw.op == OP_DIV_KM1);
    assign sqrt_start = cw.op == OP_SQRT_GO;

    always_comb
    begin
        unique case (cw.op)
            OP_DIV_LEN:
            begin
                div_dividend = total_reg;
                div_divisor  = len;
            end
            OP_DIV_KM:
            begin
                div_dividend = sum_means_reg;
                div_divisor  = k16;
            end
            OP_DIV_KS:
            begin
                div_dividend = sum_sq_reg;
                div_divisor  = k16;
            end
            OP_DIV_KM1:
            begin
                div_dividend = a_reg[ACC_W-1:0];
                div_divisor  = k16 - 16'd1;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = 16'd1;
            end
        endcase
    end

    bawe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quot)
    );

    bawe_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (quot64 << FRAC_BITS),
        .busy    (sqrt_busy),
        .root    (root)
    );

    // Sequencer: the control word picks the next step.
    always_comb
    begin
        ret_next = ret_reg;
        unique case (cw.cond)
            C_NEXT:     pc_next = pc_reg + STEP_W'(1);
            C_GOTO:     pc_next = cw.target;
            C_NO_REQ:   pc_next = take ? pc_reg + STEP_W'(1) : cw.target;
            C_FULL:     pc_next = full ? cw.target : pc_reg + STEP_W'(1);
            C_MODE0:    pc_next = !measure_mode_reg ? cw.target : pc_reg + STEP_W'(1);
            C_BUSY:     pc_next = (div_busy || sqrt_busy) ? cw.target : pc_reg + STEP_W'(1);
            C_NOT_END:  pc_next = (samples_reg < len) ? cw.target : pc_reg + STEP_W'(1);
            C_FIRST:    pc_next = (k16 <= 16'd1) ? cw.target : pc_reg + STEP_W'(1);
            C_OUT_BUSY: pc_next = (result_valid_reg && result_stall) ? cw.target
                                                                      : pc_reg + STEP_W'(1);
            C_CALL:
            begin
                pc_next  = cw.target;
                ret_next = pc_reg + STEP_W'(1);
            end
            C_RET:      pc_next = ret_reg;
            default:    pc_next = S_IDLE;
        endcase
    end

    // Datapath: one operation per control word.
    always_comb
    begin
        samples_next      = samples_reg;
        total_next        = total_reg;
        count_next        = count_reg;
        sum_means_next    = sum_means_reg;
        sum_sq_next       = sum_sq_reg;
        s_next            = s_reg;
        a_next            = a_reg;
        t_next            = t_reg;
        avg_next          = avg_reg;
        prod_next         = prod_reg;
        cross_next        = cross_reg;
        err_next          = err_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (cw.op)
            OP_ACCEPT:
            begin
                if (take)
                begin
                    s_next = item.sample[31 -: FRAC_BITS];
                    if (item.restart)
                    begin
                        samples_next   = '0;
                        total_next     = '0;
                        count_next     = '0;
                        sum_means_next = '0;
                        sum_sq_next    = '0;
                    end
                end
            end
            OP_LOAD_V:  a_next = measure_mode_reg ? WORD_W'(dev) : WORD_W'(s_reg);
            OP_ADD_V:
            begin
                total_next   = total_reg + a_reg[ACC_W-1:0];
                samples_next = samples_reg + 16'd1;
            end
            OP_MEAN:
            begin
                a_next         = quot64;
                sum_means_next = sum_means_reg + quot[ACC_W-1:0];
                samples_next   = '0;
                total_next     = '0;
                count_next     = count_reg + COUNT_BITS'(1);
            end
            OP_ADD_SQ:  sum_sq_next = sum_sq_reg + a_reg[ACC_W-1:0];
            OP_AVG:
            begin
                avg_next = quot64;
                a_next   = quot64;
            end
            OP_AVGSQ:
            begin
                t_next   = quot64;
                err_next = '0;
            end
            OP_VAR:     a_next = (t_reg > a_reg) ? t_reg - a_reg : '0;
            OP_ERR:     err_next = root;
            OP_EMIT:
            begin
                result_next.blocks_seen   = k16;
                result_next.throws        = throws_w;
                result_next.running_mean  = avg_reg[31:0];
                result_next.running_error = err_reg;
                result_next.full_res      = full;
                result_valid_next         = 1'b1;
            end
            OP_SQ_LO:   prod_next = sq_lo;
            OP_SQ_X:    cross_next = cross_w;
            OP_SQ_ADD:  prod_next = prod_reg + {cross_reg[30:0], 33'b0};
            OP_SQ_RND:  a_next = rnd_sum >> FRAC_BITS;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= 16'd1000;
            measure_mode_reg <= 1'b0;
            pc_reg           <= S_IDLE;
            ret_reg          <= S_IDLE;
            samples_reg      <= '0;
            total_reg        <= '0;
            count_reg        <= '0;
            sum_means_reg    <= '0;
            sum_sq_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (paddr[2])
                    REG_BLOCK_LENGTH: block_length_reg <= pwdata[15:0];
                    REG_MEASURE_MODE: measure_mode_reg <= pwdata[0];
                    default:
                    begin
                    end
                endcase
            end
            pc_reg           <= pc_next;
            ret_reg          <= ret_next;
            samples_reg      <= samples_next;
            total_reg        <= total_next;
            count_reg        <= count_next;
            sum_means_reg    <= sum_means_next;
            sum_sq_reg       <= sum_sq_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        a_reg      <= a_next;
        t_reg      <= t_next;
        avg_reg    <= avg_next;
        prod_reg   <= prod_next;
        cross_reg  <= cross_next;
        err_reg    <= err_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bawe_pkg::*;

    localparam int COUNT_BITS_TB = 16;
    localparam int unsigned COUNT_MAX = (1 << COUNT_BITS_TB) - 1;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES = 3000;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASES = 8;
    localparam int REQUESTS_PER_PHASE = 115;

    class block_stats_model;
        int unsigned count_max;
        logic [15:0] len_reg;
        logic        mode_reg;
        logic [15:0] in_block;
        logic [47:0] blk_total;
        logic [15:0] blocks;
        logic [47:0] mean_sum;
        logic [47:0] sq_sum;
        result_t     pending_results[$];
        int unsigned mismatches;

        function new(int unsigned cmax);
            count_max = cmax;
            len_reg = 16'd1000;
            mode_reg = 1'b0;
            mismatches = 0;
            clear_totals();
        endfunction

        function void clear_totals();
            in_block = '0;
            blk_total = '0;
            blocks = '0;
            mean_sum = '0;
            sq_sum = '0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_BLOCK_LENGTH)
            begin
                len_reg = value[15:0];
            end
            else
            begin
                mode_reg = value[0];
            end
        endfunction

        function logic [63:0] round_square(logic [63:0] x);
            return (x * x + 64'h0000_0000_8000_0000) >> 32;
        endfunction

        function logic [63:0] round_div(logic [63:0] a, logic [63:0] d);
            return (a + d / 2) / d;
        endfunction

        function logic [63:0] floor_root(logic [63:0] x);
            logic [63:0] rem;
            logic [63:0] root;
            logic [63:0] bitv;
            rem = x;
            root = '0;
            bitv = 64'h4000_0000_0000_0000;
            while (bitv > rem)
            begin
                bitv = bitv >> 2;
            end
            while (bitv != 0)
            begin
                if (rem >= root + bitv)
                begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        // Returns whether the request was used rather than ignored.
        function bit note_request(item_t req);
            logic [63:0] s;
            logic [63:0] dev;
            logic [63:0] v;
            logic [63:0] lenv;
            logic [63:0] mean;
            logic [63:0] k;
            logic [63:0] avg;
            logic [63:0] avg_sq;
            logic [63:0] m2;
            logic [63:0] spread;
            logic [63:0] err;
            logic [63:0] prod;
            result_t     r;
            s = {32'd0, req.sample};
            lenv = (len_reg == 16'd0) ? 64'd1 : {48'd0, len_reg};
            if (req.restart)
            begin
                clear_totals();
            end
            if (blocks >= count_max)
            begin
                return 1'b0;
            end
            if (mode_reg)
            begin
                dev = (s >= 64'h8000_0000) ? s - 64'h8000_0000 : 64'h8000_0000 - s;
                v = round_square(dev);
            end
            else
            begin
                v = s;
            end
            blk_total = blk_total + v;
            in_block = in_block + 16'd1;
            if ({48'd0, in_block} < lenv)
            begin
                return 1'b1;
            end
            mean = round_div({16'd0, blk_total}, lenv);
            mean_sum = mean_sum + mean;
            sq_sum = sq_sum + round_square(mean);
            blocks = blocks + 16'd1;
            in_block = '0;
            blk_total = '0;
            k = {48'd0, blocks};
            avg = round_div({16'd0, mean_sum}, k);
            avg_sq = round_div({16'd0, sq_sum}, k);
            err = '0;
            if (k > 1)
            begin
                m2 = round_square(avg);
                spread = (avg_sq > m2) ? avg_sq - m2 : 64'd0;
                spread = round_div(spread, k - 1);
                err = floor_root(spread << 32);
            end
            prod = k * lenv;
            r.blocks_seen = k[15:0];
            r.throws = prod[31:0];
            r.running_mean = avg[31:0];
            r.running_error = err[31:0];
            r.full_res = (k >= count_max);
            pending_results.push_back(r);
            return 1'b1;
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("result arrived with none predicted: blocks_seen %0d", got.blocks_seen);
                mismatches++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.blocks_seen !== exp_r.blocks_seen)
            begin
                $error("blocks_seen: expected %0d, got %0d", exp_r.blocks_seen, got.blocks_seen);
                mismatches++;
            end
            if (got.throws !== exp_r.throws)
            begin
                $error("throws: expected %0d, got %0d", exp_r.throws, got.throws);
                mismatches++;
            end
            if (got.running_mean !== exp_r.running_mean)
            begin
                $error("running_mean: expected %h, got %h", exp_r.running_mean,
                       got.running_mean);
                mismatches++;
            end
            if (got.running_error !== exp_r.running_error)
            begin
                $error("running_error: expected %h, got %h", exp_r.running_error,
                       got.running_error);
                mismatches++;
            end
            if (got.full_res !== exp_r.full_res)
            begin
                $error("full_res: expected %0b, got %0b", exp_r.full_res, got.full_res);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;

    block_stats_model sb;
    int tx_pct = 0;
    int rx_pct = 0;
    int counted = 0;
    int hold_left = 0;
    bit hold_pending = 1'b0;
    int cycles = 0;

    blocking_average_with_error #(
        .FRAC_BITS  (32),
        .COUNT_BITS (COUNT_BITS_TB)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: takes results and decides the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result);
        end
        if (hold_pending)
        begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
        end
    end

    task automatic send_request(input logic [31:0] smp, input logic rst_flag);
        item_t req;
        req.sample = smp;
        req.restart = rst_flag;
        while (tx_pct != 0 && $urandom_range(99) < tx_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= req;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        if (sb.note_request(req))
        begin
            counted++;
        end
    endtask

    task automatic random_request();
        logic [31:0] smp;
        logic [31:0] corners [4];
        corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        if ($urandom_range(7) == 0)
        begin
            smp = corners[$urandom_range(3)];
        end
        else
        begin
            smp = $urandom;
        end
        send_request(smp, $urandom_range(79) == 0);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    // Waits until every predicted result has left and the sequencer has gone quiet.
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int target;
        logic [15:0] len_sel;
        sb = new(COUNT_MAX);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset length, then a zero length (taken as one) closes the block at once.
        repeat (3) send_request(32'hFFFF_FFFF, 1'b0);
        drain();
        write_reg(REG_BLOCK_LENGTH, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 1'b0);

        drain();
        write_reg(REG_BLOCK_LENGTH, 32'hFFFF_0002);
        send_request(32'h0000_0000, 1'b1);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'h7FFF_FFFF, 1'b0);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);

        drain();
        write_reg(REG_MEASURE_MODE, 32'hFFFF_FFFF);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'h7FFF_FFFF, 1'b0);

        // Mode switched halfway through a block.
        drain();
        write_reg(REG_BLOCK_LENGTH, 32'd4);
        repeat (2) send_request($urandom, 1'b0);
        drain();
        write_reg(REG_MEASURE_MODE, 32'hFFFF_FFFE);
        repeat (2) send_request($urandom, 1'b0);

        // Longest block, then the length lowered to the number of samples already taken.
        drain();
        write_reg(REG_BLOCK_LENGTH, 32'hFFFF_FFFF);
        repeat (3) send_request($urandom, 1'b0);
        drain();
        write_reg(REG_BLOCK_LENGTH, 32'd3);
        send_request($urandom, 1'b0);

        // Restart in the middle of a block.
        send_request($urandom, 1'b0);
        send_request($urandom, 1'b0);
        send_request($urandom, 1'b1);
        send_request($urandom, 1'b0);
        send_request($urandom, 1'b0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase % 4)
                0:
                begin
                    tx_pct = 0;
                    rx_pct = 0;
                end
                1:
                begin
                    tx_pct = 70;
                    rx_pct = 0;
                end
                2:
                begin
                    tx_pct = 0;
                    rx_pct = 70;
                end
                default:
                begin
                    tx_pct = 14;
                    rx_pct = 14;
                end
            endcase
            case ($urandom_range(4))
                0: len_sel = 16'd0;
                1: len_sel = 16'd1;
                2: len_sel = 16'd2;
                3: len_sel = 16'($urandom_range(8, 1));
                default: len_sel = 16'($urandom_range(24, 3));
            endcase
            if (phase == 0)
            begin
                len_sel = 16'd1;
            end
            write_reg(REG_BLOCK_LENGTH, {16'($urandom), len_sel});
            write_reg(REG_MEASURE_MODE, {31'($urandom), 1'($urandom)});
            if (phase == 0)
            begin
                hold_pending = 1'b1;
            end
            target = counted + REQUESTS_PER_PHASE;
            while (counted < target)
            begin
                random_request();
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/bawe_pkg.sv
src/bawe_div.sv
src/bawe_isqrt.sv
src/blocking_average_with_error.sv
sim/tb.sv
